// File: src/gsp_pkg.sv
package gsp_pkg;

    localparam int DimBits  = 16;
    localparam int FracBits = 16;
    localparam int NormW    = FracBits + 1;
    localparam int NumW     = 17;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_PIXEL  = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [1:0] ERR_MAGIC    = 2'd0;
    localparam logic [1:0] ERR_DIGIT    = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW = 2'd2;
    localparam logic [1:0] ERR_ZEROMAX  = 2'd3;

    localparam logic [2:0] PH_MAGIC  = 3'd0;
    localparam logic [2:0] PH_WIDTH  = 3'd1;
    localparam logic [2:0] PH_HEIGHT = 3'd2;
    localparam logic [2:0] PH_MAXVAL = 3'd3;
    localparam logic [2:0] PH_APIX   = 3'd4;
    localparam logic [2:0] PH_BHI    = 3'd5;
    localparam logic [2:0] PH_BLO    = 3'd6;

    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_P    = 8'h50;
    localparam logic [7:0] CH_2    = 8'h32;
    localparam logic [7:0] CH_5    = 8'h35;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_LF   = 8'h0a;
    localparam logic [15:0] BYTE_MAX = 16'd255;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_file;
    } gsp_in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] pixel_raw;
        logic [16:0] pixel_norm;
        logic [15:0] row;
        logic [15:0] col;
        logic        last_pixel;
        logic [15:0] width_out;
        logic [15:0] height_out;
        logic [15:0] maxval_out;
        logic        binary_mode;
        logic [1:0]  error_code;
    } gsp_out_t;

    // controller -> datapath
    typedef struct packed {
        logic        div_start;
        logic [15:0] raw;
        logic [15:0] maxval;
    } gsp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic        busy;
        logic        done;
        logic [16:0] quot;
    } gsp_sts_t;

    function automatic logic is_space(input logic [7:0] b);
        return b == 8'd32 || b == 8'd9 || b == 8'd10 || b == 8'd13 ||
               b == 8'd11 || b == 8'd12;
    endfunction

endpackage

// File: src/graymap_stream_parser_unit.sv
// Graymap stream parser.
// Input channel (in_valid/in_stall/in_data) carries one file byte per
// transaction plus a start-of-file flag that restarts the header parse.
// Output channel (out_valid/out_stall/out_data) carries header, pixel
// and error results; a byte gives at most one result.
// Header bytes, whitespace, comments and errors are taken one byte per
// cycle unless the receiver stalls; header and error results appear
// the cycle after the byte. Each pixel runs through a bit-serial
// restoring divider for the normalised value: 32 iterations, and each
// pixel's byte or token end stalls the input until the divider is done.
// The output register holds a result; input is taken while it waits
// unless the receiver stalls, in which case the input stalls as well.
// Reset (rst_n low, asynchronous) returns to waiting for a magic with
// all header registers cleared.
module graymap_stream_parser_unit
    import gsp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  gsp_in_t  in_data,
    output logic     out_valid,
    input  logic     out_stall,
    output gsp_out_t out_data
);
    gsp_cmd_t cmd;
    gsp_sts_t sts;

    gsp_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cmd(cmd), .sts(sts)
    );

    gsp_divider u_div (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts)
    );
endmodule

// File: src/gsp_divider.sv
module gsp_divider
    import gsp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  gsp_cmd_t cmd,
    output gsp_sts_t sts
);
    localparam int DivW = 16 + FracBits;
    localparam int CntW = $clog2(DivW + 1);

    logic [DivW-1:0] num_reg, num_next;
    logic [16:0]     rem_reg, rem_next;
    logic [15:0]     den_reg, den_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [17:0]     trial;
    logic [16:0]     shifted;

    // restoring divide, one quotient bit a cycle; quotient shifts into num
    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[15:0], num_reg[DivW-1]};
        trial     = {1'b0, shifted} - {2'b00, den_reg};
        if (cmd.div_start)
        begin
            num_next  = {cmd.raw, {FracBits{1'b0}}};
            rem_next  = '0;
            den_next  = cmd.maxval;
            cnt_next  = CntW'(DivW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[17])
            begin
                rem_next = trial[16:0];
                num_next = {num_reg[DivW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                num_next = {num_reg[DivW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    // saturate at one
    always_comb
    begin
        sts.busy = busy_reg;
        sts.done = done_reg;
        if (num_reg > DivW'(1 << FracBits))
            sts.quot = 17'(1 << FracBits);
        else
            sts.quot = num_reg[16:0];
    end
endmodule

// File: src/gsp_ctrl.sv
module gsp_ctrl
    import gsp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  gsp_in_t  in_data,
    output logic     out_valid,
    input  logic     out_stall,
    output gsp_out_t out_data,
    output gsp_cmd_t cmd,
    input  gsp_sts_t sts
);
    logic [2:0]  phase_reg, phase_next;
    logic        cmt_reg, cmt_next;
    logic        tok_reg, tok_next;
    logic [16:0] acc_reg, acc_next;
    logic [1:0]  mg_reg, mg_next;
    logic [15:0] w_reg, w_next, h_reg, h_next, mx_reg, mx_next;
    logic        bin_reg, bin_next;
    logic [15:0] rc_reg, rc_next, cc_reg, cc_next;
    logic [7:0]  hb_reg, hb_next;
    logic        ov_reg, ov_next;
    gsp_out_t    od_reg, od_next;
    logic        pend_reg, pend_next;

    logic        acc_in;
    logic [7:0]  b;
    logic [20:0] nxt;
    logic [16:0] lim;
    logic        pix;
    logic [15:0] praw;
    logic        last;
    logic [16:0] rc1, cc1;
    gsp_out_t    res;
    logic        emit;
    logic        rst_parse;
    logic [2:0]  ph;
    logic        cm, tk;
    logic [16:0] ac;
    logic [1:0]  mg;

    assign in_stall  = pend_reg || sts.busy || sts.done || (ov_reg && out_stall);
    assign acc_in    = in_valid && !in_stall;
    assign out_valid = ov_reg;
    assign out_data  = od_reg;
    assign b         = in_data.data_byte;
    assign rc1       = {1'b0, rc_reg} + 17'd1;
    assign cc1       = {1'b0, cc_reg} + 17'd1;
    assign last      = rc1 >= {1'b0, h_reg} && cc1 >= {1'b0, w_reg};

    always_comb
    begin
        phase_next = phase_reg; cmt_next = cmt_reg; tok_next = tok_reg;
        acc_next = acc_reg; mg_next = mg_reg; w_next = w_reg; h_next = h_reg;
        mx_next = mx_reg; bin_next = bin_reg; rc_next = rc_reg; cc_next = cc_reg;
        hb_next = hb_reg; ov_next = ov_reg; od_next = od_reg; pend_next = pend_reg;
        res = '0; emit = 1'b0; pix = 1'b0; praw = '0; rst_parse = 1'b0;
        nxt = '0; lim = 17'hffff;
        cmd = '0;
        cmd.maxval = mx_reg;
        ph = phase_reg; cm = cmt_reg; tk = tok_reg; ac = acc_reg; mg = mg_reg;

        if (ov_reg && !out_stall)
            ov_next = 1'b0;

        if (acc_in)
        begin
            if (in_data.start_of_file || phase_reg > PH_BLO)
            begin
                ph = PH_MAGIC; cm = 1'b0; tk = 1'b0; ac = '0; mg = '0;
            end
            phase_next = ph; cmt_next = cm; tok_next = tk; acc_next = ac;
            mg_next = mg;
            if (ph == PH_BHI)
            begin
                if (mx_reg > BYTE_MAX)
                begin
                    hb_next = b; phase_next = PH_BLO;
                end
                else
                begin
                    pix = 1'b1; praw = {8'd0, b};
                end
            end
            else if (ph == PH_BLO)
            begin
                phase_next = PH_BHI; pix = 1'b1; praw = {hb_reg, b};
            end
            else if (cm)
            begin
                if (b == CH_LF)
                    cmt_next = 1'b0;
            end
            else if (!tk && is_space(b))
            begin
            end
            else if (!tk && b == CH_HASH)
                cmt_next = 1'b1;
            else if (!tk && ph == PH_MAGIC)
            begin
                if (b != CH_P)
                begin
                    emit = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_MAGIC;
                    rst_parse = 1'b1;
                end
                else
                begin
                    tok_next = 1'b1; mg_next = 2'd1;
                end
            end
            else if (ph == PH_MAGIC)
            begin
                if (is_space(b))
                begin
                    if (mg < 2'd2)
                    begin
                        emit = 1'b1; res.kind = KIND_ERROR;
                        res.error_code = ERR_MAGIC; rst_parse = 1'b1;
                    end
                    else
                    begin
                        bin_next = (mg == 2'd3); tok_next = 1'b0; mg_next = '0;
                        phase_next = PH_WIDTH;
                    end
                end
                else if (mg == 2'd1 && b == CH_2)
                    mg_next = 2'd2;
                else if (mg == 2'd1 && b == CH_5)
                    mg_next = 2'd3;
                else
                begin
                    emit = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_MAGIC;
                    rst_parse = 1'b1;
                end
            end
            else
            begin
                // number token: a fresh token starts from zero
                if (!tk)
                    ac = '0;
                tok_next = 1'b1;
                acc_next = ac;
                if (is_space(b))
                begin
                    tok_next = 1'b0; acc_next = '0;
                    unique case (ph)
                        PH_WIDTH:
                        begin
                            w_next = ac[15:0]; phase_next = PH_HEIGHT;
                        end
                        PH_HEIGHT:
                        begin
                            h_next = ac[15:0]; phase_next = PH_MAXVAL;
                        end
                        PH_MAXVAL:
                        begin
                            emit = 1'b1;
                            if (ac == '0)
                            begin
                                res.kind = KIND_ERROR; res.error_code = ERR_ZEROMAX;
                                rst_parse = 1'b1;
                            end
                            else
                            begin
                                mx_next = ac[15:0]; rc_next = '0; cc_next = '0;
                                res.kind = KIND_HEADER; res.width_out = w_reg;
                                res.height_out = h_reg; res.maxval_out = ac[15:0];
                                res.binary_mode = bin_reg;
                                if (w_reg == '0 || h_reg == '0)
                                    rst_parse = 1'b1;
                                else
                                    phase_next = bin_reg ? PH_BHI : PH_APIX;
                            end
                        end
                        default:
                        begin
                            pix = 1'b1; praw = ac[15:0];
                        end
                    endcase
                end
                else if (b < CH_0 || b > CH_9)
                begin
                    emit = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_DIGIT;
                    rst_parse = 1'b1;
                end
                else
                begin
                    nxt = 21'(ac) * 21'd10 + 21'(b - CH_0);
                    if (ph == PH_WIDTH || ph == PH_HEIGHT)
                        lim = 17'((1 << DimBits) - 1);
                    if (nxt > 21'(lim))
                    begin
                        emit = 1'b1; res.kind = KIND_ERROR;
                        res.error_code = ERR_OVERFLOW; rst_parse = 1'b1;
                    end
                    else
                        acc_next = nxt[16:0];
                end
            end

            if (pix)
            begin
                res.kind = KIND_PIXEL; res.pixel_raw = praw;
                res.row = rc_reg; res.col = cc_reg; res.last_pixel = last;
                if (last)
                begin
                    rc_next = '0; cc_next = '0; rst_parse = 1'b1;
                end
                else if (cc1 >= {1'b0, w_reg})
                begin
                    cc_next = '0; rc_next = rc1[15:0];
                end
                else
                    cc_next = cc1[15:0];
                // hold the result until the divider finishes
                od_next = res; pend_next = 1'b1;
                cmd.div_start = 1'b1; cmd.raw = praw;
            end
            else if (emit)
            begin
                od_next = res; ov_next = 1'b1;
            end
            if (rst_parse)
            begin
                phase_next = PH_MAGIC; cmt_next = 1'b0; tok_next = 1'b0;
                acc_next = '0; mg_next = '0;
            end
        end

        if (sts.done)
        begin
            od_next.pixel_norm = sts.quot; ov_next = 1'b1; pend_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_MAGIC; cmt_reg <= 1'b0; tok_reg <= 1'b0; acc_reg <= '0;
            mg_reg <= '0; w_reg <= '0; h_reg <= '0; mx_reg <= '0; bin_reg <= 1'b0;
            rc_reg <= '0; cc_reg <= '0; hb_reg <= '0; ov_reg <= 1'b0; pend_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next; cmt_reg <= cmt_next; tok_reg <= tok_next;
            acc_reg <= acc_next; mg_reg <= mg_next; w_reg <= w_next; h_reg <= h_next;
            mx_reg <= mx_next; bin_reg <= bin_next; rc_reg <= rc_next;
            cc_reg <= cc_next; hb_reg <= hb_next; ov_reg <= ov_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        od_reg <= od_next;
    end
endmodule
